// ===== hw/rtl/tmh_pkg.sv =====
`timescale 1ns / 1ps

package tmh_pkg;

    localparam int MAX_TIMERS = 32;
    localparam int SLOT_W     = $clog2(MAX_TIMERS);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int TIME_BITS  = 48;
    localparam int VAL_W      = 48;
    localparam int CFG_W      = 32;
    localparam int KIND_W     = 4;
    localparam int STAT_W     = 3;
    localparam int NFIRE_W    = 7;
    localparam int MAX_FIRE   = 64;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    // input item kinds
    localparam logic [KIND_W-1:0] K_ADD_ONE  = 4'd0;
    localparam logic [KIND_W-1:0] K_ADD_REP  = 4'd1;
    localparam logic [KIND_W-1:0] K_CANCEL   = 4'd2;
    localparam logic [KIND_W-1:0] K_RESCHED  = 4'd3;
    localparam logic [KIND_W-1:0] K_PAUSE    = 4'd4;
    localparam logic [KIND_W-1:0] K_RESUME   = 4'd5;
    localparam logic [KIND_W-1:0] K_TICK     = 4'd6;
    localparam logic [KIND_W-1:0] K_REMAIN   = 4'd7;
    localparam logic [KIND_W-1:0] K_NEXT     = 4'd8;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_INVAL   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STAT_W-1:0] ST_INACT   = 3'd3;
    localparam logic [STAT_W-1:0] ST_FIRED   = 3'd4;
    localparam logic [STAT_W-1:0] ST_NONE    = 3'd5;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_MIN_DELAY = 2'd0;
    localparam logic [1:0] CFG_MIN_INTV  = 2'd1;
    localparam logic [1:0] CFG_MAX_DELAY = 2'd2;

    localparam logic [CFG_W-1:0] MAX_DELAY_RST = 32'd86400000;
    localparam logic [CFG_W-1:0] MIN_INTV_RST  = 32'd1;

    typedef struct packed {
        logic [SLOT_W-1:0]    slot;
        logic [TIME_BITS-1:0] expiry;
    } t_hp_ent;

    typedef enum logic [4:0] {
        S_IDLE, S_DEC, S_RDPOS, S_RDHP, S_ROOT, S_ROOT_Q, S_FIRE, S_RM, S_RM_Q,
        S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP, S_PLACE, S_TK_END, S_EMIT
    } t_state;

    // saturating add: the carry out means the sum passed the maximum
    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [CFG_W-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {{(TIME_BITS+1-CFG_W){1'b0}}, b};
        return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
    endfunction

    function automatic logic [TIME_BITS-1:0] time_left(input logic [TIME_BITS-1:0] e,
                                                       input logic [TIME_BITS-1:0] n);
        return (e > n) ? (e - n) : '0;
    endfunction

endpackage

// ===== hw/rtl/tmh_in_if.sv =====
`timescale 1ns / 1ps

interface tmh_in_if
    import tmh_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   handle;
    logic [CFG_W-1:0]    delay;

    modport source (output valid, kind, handle, delay, input ready);
    modport sink   (input valid, kind, handle, delay, output ready);
endinterface

// ===== hw/rtl/tmh_out_if.sv =====
`timescale 1ns / 1ps

interface tmh_out_if
    import tmh_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [SLOT_W-1:0]   out_handle;
    logic [VAL_W-1:0]    value;
    logic                last;

    modport source (output valid, status, out_handle, value, last, input ready);
    modport sink   (input valid, status, out_handle, value, last, output ready);
endinterface

// ===== hw/rtl/timer_min_heap_scheduler_core.sv =====
`timescale 1ns / 1ps
// Timer queue kept as a binary min-heap of up to 32 timers in on-chip memory.
// i_in  : commands (add one-shot/repeating, cancel, reschedule, pause, resume,
//         tick, remaining, next delay); a transfer when valid and ready are high.
// o_out : results with status, handle, value and a last marker; a tick gives
//         one result per fired timer (or one none result), the final one carrying last.
// i_cfg_*: register writes (min delay, min interval, max delay), which the user
// makes only while idle; the block itself does not enforce this. One command is
// worked at a time. Commands that move an entry walk at most 5 heap levels,
// with a registered read of the heap memory before each compare. A tick inspects
// the root again after each fired or dropped timer; each fired timer adds its
// sift and emit steps, each dropped (cancelled) timer only its sift.
// Results sit in an output register, so the next command is taken while a
// result waits; when the receiver stalls, a command with more results holds
// in its emit step until the register is free.
// Reset (synchronous, active low) empties the heap, clears the counter and all
// slot flags and restores the register defaults; no clearing pass is needed.
module timer_min_heap_scheduler_core
    import tmh_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    tmh_in_if.sink           i_in,
    tmh_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    // memories
    t_hp_ent           hp_mem  [MAX_TIMERS];
    logic [SLOT_W-1:0] pos_mem [MAX_TIMERS];
    logic [CFG_W-1:0]  iv_mem  [MAX_TIMERS];
    logic [CFG_W-1:0]  pl_mem  [MAX_TIMERS];

    t_hp_ent           hpa_q, hpb_q;
    logic [SLOT_W-1:0] pos_q;
    logic [CFG_W-1:0]  iv_q, pl_q;

    logic              hp_we, hp_rea, hp_reb, pos_we, pos_re, iv_we, iv_re, pl_we, pl_re;
    logic [SLOT_W-1:0] hp_wa, hp_ra, hp_rb, pos_wa, pos_wd, pos_ra;
    logic [SLOT_W-1:0] iv_wa, iv_ra, pl_wa, pl_ra;
    t_hp_ent           hp_wd;
    logic [CFG_W-1:0]  iv_wd, pl_wd;

    // control and data registers
    t_state                r_state, n_state, r_ret, n_ret, r_after, n_after;
    logic [KIND_W-1:0]     r_kind, n_kind;
    logic [SLOT_W-1:0]     r_h, n_h;
    logic [CFG_W-1:0]      r_d, n_d;
    logic [TIME_BITS-1:0]  r_now, n_now;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [MAX_TIMERS-1:0] r_used, n_used, r_canc, n_canc, r_paus, n_paus;
    t_hp_ent               r_cur, n_cur;
    logic [SLOT_W-1:0]     r_pos, n_pos;
    logic                  r_moved, n_moved, r_has_r, n_has_r;
    logic [NFIRE_W-1:0]    r_nfire, n_nfire;
    logic                  r_pend, n_pend;
    logic [SLOT_W-1:0]     r_pend_h, n_pend_h;
    logic [STAT_W-1:0]     r_res_st, n_res_st;
    logic [SLOT_W-1:0]     r_res_h, n_res_h;
    logic [VAL_W-1:0]      r_res_val, n_res_val;
    logic                  r_res_last, n_res_last;
    logic                  r_ov, n_ov;
    logic [STAT_W-1:0]     r_o_st;
    logic [SLOT_W-1:0]     r_o_h;
    logic [VAL_W-1:0]      r_o_val;
    logic                  r_o_last, o_load;
    logic [CFG_W-1:0]      r_min_d, r_min_i, r_max_d;

    // helpers
    logic [SLOT_W-1:0]    par_idx, free_slot;
    logic                 free_ok;
    logic [SLOT_W+1:0]    l_idx, r_idx;
    logic [CFG_W-1:0]     lo_lim, clamp_d, clamp_pl;
    logic [TIME_BITS-1:0] left_t;
    t_hp_ent              best;
    logic                 best_l, best_r;

    assign par_idx = (r_pos - SLOT_W'(1)) >> 1;
    assign l_idx   = {1'b0, r_pos, 1'b1};
    assign r_idx   = l_idx + (SLOT_W+2)'(1);
    assign lo_lim  = (r_kind == K_ADD_REP) ? r_min_i : r_min_d;
    assign clamp_d = (r_d > r_max_d) ? r_max_d : r_d;
    assign clamp_pl = (pl_q > r_max_d) ? r_max_d : pl_q;
    assign left_t  = time_left(hpa_q.expiry, r_now);

    // first free slot
    always_comb begin
        free_ok   = 1'b0;
        free_slot = '0;
        for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_ok   = 1'b1;
                free_slot = SLOT_W'(i);
            end
        end
    end

    // smaller child, left wins ties
    always_comb begin
        best_l = hpa_q.expiry < r_cur.expiry;
        best   = best_l ? hpa_q : r_cur;
        best_r = r_has_r && (hpb_q.expiry < best.expiry);
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign o_load     = !r_ov || o_out.ready;

    // next state and datapath control
    always_comb begin
        n_state = r_state;   n_ret = r_ret;       n_after = r_after;
        n_kind = r_kind;     n_h = r_h;           n_d = r_d;
        n_now = r_now;       n_cnt = r_cnt;
        n_used = r_used;     n_canc = r_canc;     n_paus = r_paus;
        n_cur = r_cur;       n_pos = r_pos;       n_moved = r_moved;  n_has_r = r_has_r;
        n_nfire = r_nfire;   n_pend = r_pend;     n_pend_h = r_pend_h;
        n_res_st = r_res_st; n_res_h = r_res_h;   n_res_val = r_res_val;
        n_res_last = r_res_last;
        hp_we = 1'b0;  hp_wa = '0;  hp_wd = r_cur;
        hp_rea = 1'b0; hp_ra = '0;  hp_reb = 1'b0; hp_rb = '0;
        pos_we = 1'b0; pos_wa = '0; pos_wd = '0; pos_re = 1'b0; pos_ra = r_h;
        iv_we = 1'b0;  iv_wa = r_h; iv_wd = '0;  iv_re = 1'b0;  iv_ra = r_h;
        pl_we = 1'b0;  pl_wa = r_h; pl_wd = '0;  pl_re = 1'b0;  pl_ra = r_h;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_kind  = i_in.kind;
                    n_h     = i_in.handle;
                    n_d     = i_in.delay;
                    n_state = S_DEC;
                end
            end

            S_DEC: begin
                n_res_h = '0; n_res_val = '0; n_res_last = 1'b1; n_res_st = ST_OK;
                n_after = S_IDLE;
                if (r_kind == K_ADD_ONE || r_kind == K_ADD_REP) begin
                    n_state = S_EMIT;
                    if (r_d < lo_lim || r_d > r_max_d) begin
                        n_res_st = ST_INVAL;
                    end else if (!free_ok) begin
                        n_res_st = ST_FULL;
                    end else begin
                        iv_we   = 1'b1; iv_wa = free_slot;
                        iv_wd   = (r_kind == K_ADD_REP) ? r_d : '0;
                        pl_we   = 1'b1; pl_wa = free_slot;
                        n_used[free_slot] = 1'b1;
                        n_canc[free_slot] = 1'b0;
                        n_paus[free_slot] = 1'b0;
                        n_cnt   = r_cnt + CNT_W'(1);
                        n_cur   = '{slot: free_slot, expiry: sat_add(r_now, r_d)};
                        n_pos   = r_cnt[SLOT_W-1:0];
                        n_moved = 1'b0;
                        n_res_h = free_slot;
                        n_ret   = S_EMIT;
                        n_state = S_UP_RD;
                    end
                end else if (r_kind == K_CANCEL || r_kind == K_RESCHED || r_kind == K_PAUSE
                             || r_kind == K_RESUME || r_kind == K_REMAIN) begin
                    n_state = S_EMIT;
                    if (!r_used[r_h] || r_canc[r_h]
                        || (r_kind == K_PAUSE && r_paus[r_h])
                        || (r_kind == K_RESUME && !r_paus[r_h])) begin
                        n_res_st = ST_INACT;
                    end else if (r_kind == K_CANCEL) begin
                        n_canc[r_h] = 1'b1;
                    end else begin
                        pos_re  = 1'b1;
                        iv_re   = 1'b1;
                        pl_re   = 1'b1;
                        n_state = S_RDPOS;
                    end
                end else if (r_kind == K_TICK) begin
                    if (r_now < TIME_MAX - TIME_BITS'(1)) begin
                        n_now = r_now + TIME_BITS'(1);
                    end
                    n_nfire = '0;
                    n_pend  = 1'b0;
                    n_state = S_ROOT;
                end else if (r_kind == K_NEXT) begin
                    n_state = S_ROOT;
                end else begin
                    n_state = S_IDLE;
                end
            end

            S_RDPOS: begin
                n_pos   = pos_q;
                hp_rea  = 1'b1;
                hp_ra   = pos_q;
                n_state = S_RDHP;
            end

            // per-command update with the entry's current expiry at hand
            S_RDHP: begin
                n_cur.slot = r_h;
                n_moved    = 1'b0;
                n_ret      = S_EMIT;
                n_state    = S_UP_RD;
                unique case (r_kind)
                    K_RESCHED: begin
                        n_cur.expiry = sat_add(r_now, clamp_d);
                        if (iv_q != '0) begin
                            iv_we = 1'b1;
                            iv_wd = clamp_d;
                        end
                    end
                    K_PAUSE: begin
                        pl_we = 1'b1;
                        pl_wd = (left_t > TIME_BITS'({CFG_W{1'b1}})) ? '1 : left_t[CFG_W-1:0];
                        n_paus[r_h]  = 1'b1;
                        n_cur.expiry = TIME_MAX;
                    end
                    K_RESUME: begin
                        n_cur.expiry = sat_add(r_now, clamp_pl);
                        n_paus[r_h]  = 1'b0;
                        pl_we        = 1'b1;
                    end
                    default: begin
                        n_res_val = left_t;
                        n_state   = S_EMIT;
                    end
                endcase
            end

            // inspect the root: drop cancelled, fire due, or answer next delay
            S_ROOT: begin
                if (r_kind == K_TICK && r_nfire == NFIRE_W'(MAX_FIRE)) begin
                    n_state = S_TK_END;
                end else if (r_cnt == '0) begin
                    if (r_kind == K_TICK) begin
                        n_state = S_TK_END;
                    end else begin
                        n_res_st = ST_EMPTY; n_res_h = '0; n_res_val = '0;
                        n_res_last = 1'b1;   n_after = S_IDLE; n_state = S_EMIT;
                    end
                end else begin
                    hp_rea  = 1'b1;
                    hp_ra   = '0;
                    n_state = S_ROOT_Q;
                end
            end

            S_ROOT_Q: begin
                if (r_canc[hpa_q.slot]) begin
                    n_used[hpa_q.slot] = 1'b0;
                    n_canc[hpa_q.slot] = 1'b0;
                    n_paus[hpa_q.slot] = 1'b0;
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_state = S_RM;
                end else if (r_kind == K_TICK) begin
                    if (hpa_q.expiry > r_now) begin
                        n_state = S_TK_END;
                    end else begin
                        n_cur    = hpa_q;
                        iv_re    = 1'b1;
                        iv_ra    = hpa_q.slot;
                        n_nfire  = r_nfire + NFIRE_W'(1);
                        n_pend   = 1'b1;
                        n_pend_h = hpa_q.slot;
                        n_state  = S_FIRE;
                        if (r_pend) begin
                            n_res_st = ST_FIRED; n_res_h = r_pend_h; n_res_val = '0;
                            n_res_last = 1'b0;   n_after = S_FIRE;   n_state = S_EMIT;
                        end
                    end
                end else begin
                    n_res_st = ST_OK;   n_res_h = '0; n_res_val = left_t;
                    n_res_last = 1'b1;  n_after = S_IDLE; n_state = S_EMIT;
                end
            end

            // rearm a repeating timer or free a one-shot
            S_FIRE: begin
                if (iv_q != '0) begin
                    n_cur.expiry = sat_add(r_cur.expiry, iv_q);
                    n_pos   = '0;
                    n_moved = 1'b0;
                    n_ret   = S_ROOT;
                    n_state = S_UP_RD;
                end else begin
                    n_used[r_cur.slot] = 1'b0;
                    n_canc[r_cur.slot] = 1'b0;
                    n_paus[r_cur.slot] = 1'b0;
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_state = S_RM;
                end
            end

            // move the last entry to the root
            S_RM: begin
                if (r_cnt == '0) begin
                    n_state = S_ROOT;
                end else begin
                    hp_rea  = 1'b1;
                    hp_ra   = r_cnt[SLOT_W-1:0];
                    n_state = S_RM_Q;
                end
            end

            S_RM_Q: begin
                n_cur   = hpa_q;
                n_pos   = '0;
                n_moved = 1'b0;
                n_ret   = S_ROOT;
                n_state = S_UP_RD;
            end

            // sift up with a hole; falls into sift down if nothing moved
            S_UP_RD: begin
                if (r_pos == '0) begin
                    n_state = S_DN_RD;
                end else begin
                    hp_rea  = 1'b1;
                    hp_ra   = par_idx;
                    n_state = S_UP_CMP;
                end
            end

            S_UP_CMP: begin
                if (r_cur.expiry < hpa_q.expiry) begin
                    hp_we   = 1'b1; hp_wa = r_pos; hp_wd = hpa_q;
                    pos_we  = 1'b1; pos_wa = hpa_q.slot; pos_wd = r_pos;
                    n_pos   = par_idx;
                    n_moved = 1'b1;
                    n_state = S_UP_RD;
                end else begin
                    n_state = r_moved ? S_PLACE : S_DN_RD;
                end
            end

            S_DN_RD: begin
                if (l_idx < (SLOT_W+2)'(r_cnt)) begin
                    hp_rea  = 1'b1; hp_ra = l_idx[SLOT_W-1:0];
                    hp_reb  = 1'b1; hp_rb = r_idx[SLOT_W-1:0];
                    n_has_r = r_idx < (SLOT_W+2)'(r_cnt);
                    n_state = S_DN_CMP;
                end else begin
                    n_state = S_PLACE;
                end
            end

            S_DN_CMP: begin
                if (best_r) begin
                    hp_we   = 1'b1; hp_wa = r_pos; hp_wd = hpb_q;
                    pos_we  = 1'b1; pos_wa = hpb_q.slot; pos_wd = r_pos;
                    n_pos   = r_idx[SLOT_W-1:0];
                    n_state = S_DN_RD;
                end else if (best_l) begin
                    hp_we   = 1'b1; hp_wa = r_pos; hp_wd = hpa_q;
                    pos_we  = 1'b1; pos_wa = hpa_q.slot; pos_wd = r_pos;
                    n_pos   = l_idx[SLOT_W-1:0];
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_PLACE;
                end
            end

            S_PLACE: begin
                hp_we   = 1'b1; hp_wa = r_pos; hp_wd = r_cur;
                pos_we  = 1'b1; pos_wa = r_cur.slot; pos_wd = r_pos;
                n_state = r_ret;
            end

            S_TK_END: begin
                n_res_st   = r_pend ? ST_FIRED : ST_NONE;
                n_res_h    = r_pend ? r_pend_h : '0;
                n_res_val  = '0;
                n_res_last = 1'b1;
                n_after    = S_IDLE;
                n_state    = S_EMIT;
            end

            S_EMIT: begin
                if (o_load) begin
                    n_state = r_after;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_ov = r_ov && !o_out.ready;
        if (r_state == S_EMIT && o_load) begin
            n_ov = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && o_load) begin
            r_o_st   <= r_res_st;
            r_o_h    <= r_res_h;
            r_o_val  <= r_res_val;
            r_o_last <= r_res_last;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.status     = r_o_st;
    assign o_out.out_handle = r_o_h;
    assign o_out.value      = r_o_val;
    assign o_out.last       = r_o_last;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_now   <= '0;
            r_cnt   <= '0;
            r_used  <= '0;
            r_canc  <= '0;
            r_paus  <= '0;
            r_ov    <= 1'b0;
            r_pend  <= 1'b0;
            r_nfire <= '0;
            r_min_d <= '0;
            r_min_i <= MIN_INTV_RST;
            r_max_d <= MAX_DELAY_RST;
        end else begin
            r_state <= n_state;
            r_now   <= n_now;
            r_cnt   <= n_cnt;
            r_used  <= n_used;
            r_canc  <= n_canc;
            r_paus  <= n_paus;
            r_ov    <= n_ov;
            r_pend  <= n_pend;
            r_nfire <= n_nfire;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MIN_DELAY: r_min_d <= i_cfg_data;
                    CFG_MIN_INTV:  r_min_i <= i_cfg_data;
                    CFG_MAX_DELAY: r_max_d <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ret      <= n_ret;
        r_after    <= n_after;
        r_kind     <= n_kind;
        r_h        <= n_h;
        r_d        <= n_d;
        r_cur      <= n_cur;
        r_pos      <= n_pos;
        r_moved    <= n_moved;
        r_has_r    <= n_has_r;
        r_pend_h   <= n_pend_h;
        r_res_st   <= n_res_st;
        r_res_h    <= n_res_h;
        r_res_val  <= n_res_val;
        r_res_last <= n_res_last;
    end

    // heap memory: one write port, two read ports
    always_ff @(posedge i_clk) begin
        if (hp_we) begin
            hp_mem[hp_wa] <= hp_wd;
        end
        if (hp_rea) begin
            hpa_q <= hp_mem[hp_ra];
        end
        if (hp_reb) begin
            hpb_q <= hp_mem[hp_rb];
        end
    end

    // per-slot memories
    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            pos_mem[pos_wa] <= pos_wd;
        end
        if (pos_re) begin
            pos_q <= pos_mem[pos_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (iv_we) begin
            iv_mem[iv_wa] <= iv_wd;
        end
        if (iv_re) begin
            iv_q <= iv_mem[iv_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pl_we) begin
            pl_mem[pl_wa] <= pl_wd;
        end
        if (pl_re) begin
            pl_q <= pl_mem[pl_ra];
        end
    end

endmodule

// ===== tb/tb_timer_min_heap_scheduler_core.sv =====
`timescale 1ns / 1ps

module tb_timer_min_heap_scheduler_core;
    import tmh_pkg::*;

    localparam logic [KIND_W-1:0] K_UNUSED = 4'hF;   // not a command: no result
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 1000;
    localparam int RANDOM_ITEMS   = 350;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] handle;
        logic [VAL_W-1:0]  value;
        logic              last;
    } t_result;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] handle;
        logic [CFG_W-1:0]  delay;
        bit                typed;
        logic [STAT_W-1:0] status;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    tmh_in_if  cmd_if ();
    tmh_out_if res_if ();

    timer_min_heap_scheduler_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (cmd_if.sink),
        .o_out      (res_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow copy of the timer queue
    logic [CFG_W-1:0]     sh_min_delay, sh_min_intv, sh_max_delay;
    logic [TIME_BITS-1:0] sh_now;
    logic [TIME_BITS-1:0] sh_expiry [MAX_TIMERS];
    logic [CFG_W-1:0]     sh_intv   [MAX_TIMERS];
    logic [CFG_W-1:0]     sh_left   [MAX_TIMERS];
    bit                   sh_used   [MAX_TIMERS];
    bit                   sh_cancel [MAX_TIMERS];
    bit                   sh_pause  [MAX_TIMERS];
    int                   sh_heap   [MAX_TIMERS];
    int                   sh_pos    [MAX_TIMERS];
    int                   sh_count;

    t_result pending_results[$];
    int  errors = 0, n_results = 0, idle_cycles = 0;
    int  n_items, n_fired, n_full;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    function automatic logic [TIME_BITS-1:0] add_sat(logic [TIME_BITS-1:0] a,
                                                     logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
    endfunction

    function automatic logic [TIME_BITS-1:0] left_of(int s);
        return (sh_expiry[s] > sh_now) ? sh_expiry[s] - sh_now : '0;
    endfunction

    function automatic void place(int p, int s);
        sh_heap[p] = s;
        sh_pos[s]  = p;
    endfunction

    function automatic void swap_entries(int a, int b);
        int sa, sb;
        sa = sh_heap[a];
        sb = sh_heap[b];
        place(a, sb);
        place(b, sa);
    endfunction

    function automatic void bubble_up(int p);
        int par;
        while (p > 0 && p < sh_count) begin
            par = (p - 1) / 2;
            if (sh_expiry[sh_heap[p]] >= sh_expiry[sh_heap[par]]) break;
            swap_entries(p, par);
            p = par;
        end
    endfunction

    function automatic void bubble_down(int p);
        int l, r, m;
        while (p < sh_count) begin
            l = 2 * p + 1;
            r = 2 * p + 2;
            m = p;
            if (l < sh_count && sh_expiry[sh_heap[l]] < sh_expiry[sh_heap[m]]) m = l;
            if (r < sh_count && sh_expiry[sh_heap[r]] < sh_expiry[sh_heap[m]]) m = r;
            if (m == p) break;
            swap_entries(p, m);
            p = m;
        end
    endfunction

    function automatic void pop_root();
        sh_used[sh_heap[0]]   = 0;
        sh_cancel[sh_heap[0]] = 0;
        sh_pause[sh_heap[0]]  = 0;
        sh_count--;
        if (sh_count > 0) begin
            place(0, sh_heap[sh_count]);
            bubble_down(0);
        end
    endfunction

    function automatic void purge_cancelled();
        while (sh_count > 0 && sh_cancel[sh_heap[0]]) pop_root();
    endfunction

    function automatic void expect_result(logic [STAT_W-1:0] st, int h,
                                          logic [VAL_W-1:0] v, bit lst);
        t_result r;
        r.status = st;
        r.handle = h[SLOT_W-1:0];
        r.value  = v;
        r.last   = lst;
        pending_results.push_back(r);
    endfunction

    // works out the results of one command and updates the shadow queue
    function automatic void predict_timer_results(logic [KIND_W-1:0] kind,
                                                  logic [SLOT_W-1:0] h,
                                                  logic [CFG_W-1:0] d);
        logic [CFG_W-1:0] lo, c;
        logic [TIME_BITS-1:0] lft;
        int s, n, p;
        bit ok;
        case (kind)
            K_ADD_ONE, K_ADD_REP: begin
                lo = (kind == K_ADD_REP) ? sh_min_intv : sh_min_delay;
                s = -1;
                for (int i = MAX_TIMERS - 1; i >= 0; i--) if (!sh_used[i]) s = i;
                if (d < lo || d > sh_max_delay) begin
                    expect_result(ST_INVAL, 0, 0, 1);
                end else if (s < 0) begin
                    expect_result(ST_FULL, 0, 0, 1);
                    n_full++;
                end else begin
                    sh_expiry[s] = add_sat(sh_now, TIME_BITS'(d));
                    sh_intv[s]   = (kind == K_ADD_REP) ? d : '0;
                    sh_left[s]   = '0;
                    sh_used[s]   = 1;
                    sh_cancel[s] = 0;
                    sh_pause[s]  = 0;
                    place(sh_count, s);
                    sh_count++;
                    bubble_up(sh_count - 1);
                    expect_result(ST_OK, s, 0, 1);
                end
            end
            K_CANCEL, K_RESCHED, K_PAUSE, K_RESUME, K_REMAIN: begin
                ok = sh_used[h] && !sh_cancel[h];
                if (kind == K_PAUSE && sh_pause[h]) ok = 0;
                if (kind == K_RESUME && !sh_pause[h]) ok = 0;
                if (!ok) begin
                    expect_result(ST_INACT, 0, 0, 1);
                end else if (kind == K_REMAIN) begin
                    expect_result(ST_OK, 0, left_of(h), 1);
                end else begin
                    case (kind)
                        K_CANCEL: sh_cancel[h] = 1;
                        K_RESCHED: begin
                            c = (d > sh_max_delay) ? sh_max_delay : d;
                            p = sh_pos[h];
                            sh_expiry[h] = add_sat(sh_now, TIME_BITS'(c));
                            if (sh_intv[h] > 0) sh_intv[h] = c;
                            if (p > 0 && sh_expiry[h] < sh_expiry[sh_heap[(p - 1) / 2]])
                                bubble_up(p);
                            else
                                bubble_down(p);
                        end
                        K_PAUSE: begin
                            lft = left_of(h);
                            sh_left[h]   = (lft > 48'hFFFF_FFFF) ? '1 : lft[CFG_W-1:0];
                            sh_pause[h]  = 1;
                            sh_expiry[h] = TIME_MAX;
                            bubble_down(sh_pos[h]);
                        end
                        default: begin
                            c = (sh_left[h] > sh_max_delay) ? sh_max_delay : sh_left[h];
                            sh_expiry[h] = add_sat(sh_now, TIME_BITS'(c));
                            sh_pause[h]  = 0;
                            sh_left[h]   = '0;
                            bubble_up(sh_pos[h]);
                        end
                    endcase
                    expect_result(ST_OK, 0, 0, 1);
                end
            end
            K_TICK: begin
                n = 0;
                if (sh_now < TIME_MAX - 1) sh_now++;
                while (n < MAX_FIRE) begin
                    purge_cancelled();
                    if (sh_count == 0) break;
                    s = sh_heap[0];
                    if (sh_expiry[s] > sh_now) break;
                    expect_result(ST_FIRED, s, 0, 0);
                    n++;
                    n_fired++;
                    if (sh_intv[s] > 0) begin
                        sh_expiry[s] = add_sat(sh_expiry[s], TIME_BITS'(sh_intv[s]));
                        bubble_down(0);
                    end else begin
                        pop_root();
                    end
                end
                if (n == 0) expect_result(ST_NONE, 0, 0, 1);
                else pending_results[$].last = 1;
            end
            K_NEXT: begin
                purge_cancelled();
                if (sh_count == 0) expect_result(ST_EMPTY, 0, 0, 1);
                else expect_result(ST_OK, 0, left_of(sh_heap[0]), 1);
            end
            default: ;
        endcase
    endfunction

    // ---------------- result side: random back-pressure and checking ----------------
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left   <= 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                n_results++;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result st=%0d h=%0d v=%0d last=%0b", $time,
                             res_if.status, res_if.out_handle, res_if.value, res_if.last);
                    errors++;
                end else begin
                    t_result want;
                    want = pending_results.pop_front();
                    if (res_if.status !== want.status || res_if.out_handle !== want.handle ||
                        res_if.value !== want.value || res_if.last !== want.last) begin
                        $display("%0t: mismatch expected st=%0d h=%0d v=%0d last=%0b",
                                 $time, want.status, want.handle, want.value, want.last);
                        $display("%0t:          actual   st=%0d h=%0d v=%0d last=%0b",
                                 $time, res_if.status, res_if.out_handle, res_if.value,
                                 res_if.last);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left   <= stall_left - 1;
                res_if.ready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                             : $urandom_range(0, 3);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // watchdog: no transfer on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------- command side ----------------
    task automatic send_cmd(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] h,
                            logic [CFG_W-1:0] d);
        cmd_if.valid  <= 1'b1;
        cmd_if.kind   <= kind;
        cmd_if.handle <= h;
        cmd_if.delay  <= d;
        do @(posedge i_clk); while (!cmd_if.ready);
        predict_timer_results(kind, h, d);
        n_items++;
    endtask

    // random idle time between commands, mostly short
    task automatic idle_gap();
        int gap;
        gap = 0;
        if ($urandom_range(0, 2) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_MIN_DELAY: sh_min_delay = val;
            CFG_MIN_INTV:  sh_min_intv  = val;
            default:       sh_max_delay = val;
        endcase
    endtask

    function automatic logic [CFG_W-1:0] pick_delay();
        case ($urandom_range(0, 9))
            7:       return $urandom;
            8:       return sh_max_delay;
            9:       return sh_max_delay + 1;
            default: return sh_min_delay + $urandom_range(0, 30);
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 18) return K_ADD_ONE;
        if (r < 32) return K_ADD_REP;
        if (r < 58) return K_TICK;
        if (r < 64) return K_CANCEL;
        if (r < 70) return K_RESCHED;
        if (r < 77) return K_PAUSE;
        if (r < 84) return K_RESUME;
        if (r < 91) return K_REMAIN;
        if (r < 97) return K_NEXT;
        return KIND_W'($urandom_range(9, 15));
    endfunction

    t_row directed[] = '{
        '{K_NEXT,    5'd0,  32'd0,           1, ST_EMPTY},
        '{K_TICK,    5'd0,  32'd0,           1, ST_NONE},
        '{K_REMAIN,  5'd5,  32'd0,           1, ST_INACT},
        '{K_ADD_ONE, 5'd0,  32'd0,           0, ST_OK},
        '{K_ADD_REP, 5'd0,  32'd0,           1, ST_INVAL},
        '{K_ADD_ONE, 5'd0,  32'd86400001,    1, ST_INVAL},
        '{K_ADD_REP, 5'd0,  32'd3,           0, ST_OK},
        '{K_ADD_ONE, 5'd0,  32'd86400000,    0, ST_OK},
        '{K_TICK,    5'd0,  32'd0,           0, ST_OK},
        '{K_REMAIN,  5'd1,  32'd0,           0, ST_OK},
        '{K_PAUSE,   5'd1,  32'd0,           1, ST_OK},
        '{K_PAUSE,   5'd1,  32'd0,           1, ST_INACT},
        '{K_REMAIN,  5'd1,  32'd0,           0, ST_OK},
        '{K_RESCHED, 5'd1,  32'hFFFF_FFFF,   0, ST_OK},
        '{K_RESUME,  5'd1,  32'd0,           1, ST_OK},
        '{K_RESUME,  5'd1,  32'd0,           1, ST_INACT},
        '{K_CANCEL,  5'd2,  32'd0,           1, ST_OK},
        '{K_CANCEL,  5'd2,  32'd0,           1, ST_INACT},
        '{K_NEXT,    5'd0,  32'd0,           0, ST_OK},
        '{K_UNUSED,  5'd31, 32'hFFFF_FFFF,   0, ST_OK},
        '{K_RESCHED, 5'd1,  32'd0,           0, ST_OK},
        '{K_TICK,    5'd0,  32'd0,           0, ST_OK},
        '{K_REMAIN,  5'd31, 32'd0,           1, ST_INACT},
        '{K_NEXT,    5'd0,  32'd0,           0, ST_OK}
    };

    // register settings per random phase: min delay, min interval, max delay
    logic [CFG_W-1:0] phase_cfg [5][3] = '{
        '{32'd0,         32'd1,         32'd86400000},
        '{32'd0,         32'd0,         32'hFFFF_FFFF},
        '{32'd5,         32'd10,        32'd100},
        '{32'd0,         32'd0,         32'd0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}
    };

    initial begin
        int per_phase;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        cmd_if.valid = 1'b0;
        cmd_if.kind  = '0;
        cmd_if.handle = '0;
        cmd_if.delay = '0;
        n_items = 0; n_fired = 0; n_full = 0;
        sh_min_delay = 32'd0;
        sh_min_intv  = MIN_INTV_RST;
        sh_max_delay = MAX_DELAY_RST;
        sh_now   = '0;
        sh_count = 0;
        for (int i = 0; i < MAX_TIMERS; i++) begin
            sh_used[i] = 0; sh_cancel[i] = 0; sh_pause[i] = 0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed walk on the reset register values
        foreach (directed[i]) begin
            send_cmd(directed[i].kind, directed[i].handle, directed[i].delay);
            if (directed[i].typed) pending_results[$].status = directed[i].status;
            idle_gap();
        end
        drain_results();

        // random phases, registers rewritten while idle
        per_phase = RANDOM_ITEMS / 5;
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_MIN_DELAY, phase_cfg[ph][0]);
            write_reg(CFG_MIN_INTV,  phase_cfg[ph][1]);
            write_reg(CFG_MAX_DELAY, phase_cfg[ph][2]);
            for (int k = 0; k < per_phase; k++) begin
                logic [KIND_W-1:0] kd;
                logic [SLOT_W-1:0] hd;
                kd = pick_kind();
                hd = ($urandom_range(0, 9) < 7) ? SLOT_W'($urandom_range(0, 7))
                                                : SLOT_W'($urandom_range(0, 31));
                send_cmd(kd, hd, pick_delay());
                // a run with no gaps at all now and then
                if ((k / 20) % 3 != 1) idle_gap();
            end
            drain_results();
        end

        $display("%0d commands, %0d results, %0d timer expiries, %0d full rejections",
                 n_items, n_results, n_fired, n_full);
        $display("five register settings, zero and all-ones limits included");
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/tmh_pkg.sv
hw/rtl/tmh_in_if.sv
hw/rtl/tmh_out_if.sv
hw/rtl/timer_min_heap_scheduler_core.sv
tb/tb_timer_min_heap_scheduler_core.sv
